FILE: src/sorted_array_priority_queue_assert.svh
// assertion macros used by the rtl
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SAPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sapq_pkg.sv
package sapq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_WALK_INIT,
        DP_WALK,
        DP_INS_EMPTY,
        DP_RES_OK,
        DP_RES_OVF,
        DP_RES_UNF,
        DP_REM_RD,
        DP_REM_POP
    } t_dp_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_REMOVE,
        C_EMPTY,
        C_FULL,
        C_WALK_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [3:0] {
        S_WAIT    = 4'd0,
        S_DISP    = 4'd1,
        S_ICHK    = 4'd2,
        S_IFULL   = 4'd3,
        S_WALK    = 4'd4,
        S_IDONE   = 4'd5,
        S_OVF     = 4'd6,
        S_IEMPTY  = 4'd7,
        S_REM     = 4'd8,
        S_REM2    = 4'd9,
        S_UNF     = 4'd10
    } t_step;

    // one control word: operation, hold condition, jump condition and target
    typedef struct packed {
        t_dp_op op;
        t_cond  hold;
        t_cond  jcond;
        t_step  target;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic is_remove;
        logic empty;
        logic full;
        logic walk_more;
        logic out_busy;
    } t_dp_flags;

    // control store
    function automatic t_uop ucode(input t_step s);
        t_uop u;
        u = '{op: DP_NOP, hold: C_NEVER, jcond: C_NEVER, target: S_WAIT};
        case (s)
            S_WAIT:   u = '{op: DP_LATCH,     hold: C_NO_ACCEPT, jcond: C_NEVER,
                            target: S_WAIT};
            S_DISP:   u = '{op: DP_NOP,       hold: C_NEVER,     jcond: C_IS_REMOVE,
                            target: S_REM};
            S_ICHK:   u = '{op: DP_NOP,       hold: C_NEVER,     jcond: C_EMPTY,
                            target: S_IEMPTY};
            S_IFULL:  u = '{op: DP_WALK_INIT, hold: C_NEVER,     jcond: C_FULL,
                            target: S_OVF};
            S_WALK:   u = '{op: DP_WALK,      hold: C_NEVER,     jcond: C_WALK_MORE,
                            target: S_WALK};
            S_IDONE:  u = '{op: DP_RES_OK,    hold: C_OUT_BUSY,  jcond: C_ALWAYS,
                            target: S_WAIT};
            S_OVF:    u = '{op: DP_RES_OVF,   hold: C_OUT_BUSY,  jcond: C_ALWAYS,
                            target: S_WAIT};
            S_IEMPTY: u = '{op: DP_INS_EMPTY, hold: C_NEVER,     jcond: C_ALWAYS,
                            target: S_IDONE};
            S_REM:    u = '{op: DP_REM_RD,    hold: C_NEVER,     jcond: C_EMPTY,
                            target: S_UNF};
            S_REM2:   u = '{op: DP_REM_POP,   hold: C_OUT_BUSY,  jcond: C_ALWAYS,
                            target: S_WAIT};
            S_UNF:    u = '{op: DP_RES_UNF,   hold: C_OUT_BUSY,  jcond: C_ALWAYS,
                            target: S_WAIT};
            default:  u = '{op: DP_NOP,       hold: C_NEVER,     jcond: C_ALWAYS,
                            target: S_WAIT};
        endcase
        return u;
    endfunction

    function automatic logic cond_true(input t_cond c, input t_dp_flags f);
        logic r;
        r = 1'b0;
        case (c)
            C_NEVER:     r = 1'b0;
            C_ALWAYS:    r = 1'b1;
            C_NO_ACCEPT: r = !f.in_valid;
            C_IS_REMOVE: r = f.is_remove;
            C_EMPTY:     r = f.empty;
            C_FULL:      r = f.full;
            C_WALK_MORE: r = f.walk_more;
            C_OUT_BUSY:  r = f.out_busy;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/sapq_if.sv
interface sapq_in_if
    import sapq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output operation, output item_value, input ready);
    modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface sapq_out_if
    import sapq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] removed_value;

    modport source (output valid, output status, output removed_value, input ready);
    modport sink   (input valid, input status, input removed_value, output ready);
endinterface

FILE: src/sorted_array_priority_queue.sv
// channel | dir | payload                              | handshake
// i_in    | in  | operation (1), item_value (s32)      | valid / ready
// o_out   | out | status (2), removed_value (s32)      | valid / ready
//
// an insert runs from acceptance through dispatch, the empty and full checks and
// a walk that moves n entries up one slot (at most DEPTH-1) to its result word;
// one store entry is compared and moved per cycle through the single read and
// write port of the entry store; a removal does one store read before its pop
// the next word can be accepted once a result is registered, even while
// that result still waits on o_out.ready; a new result stalls until it is taken
// reset (synchronous, active low) empties the queue; the store keeps its contents
`include "sorted_array_priority_queue_assert.svh"

module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sapq_in_if.sink    i_in,
    sapq_out_if.source o_out
);
    // control word from the microcode store, flags back from the datapath
    t_uop      w_uop;
    logic      w_hold;
    t_step     w_step;
    t_dp_flags w_flags;

    // step counter, control store and jump logic
    sapq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop),
        .o_hold  (w_hold),
        .o_step  (w_step)
    );

    // indices, walk pointer, entry store and result register
    // a held step does nothing in the datapath
    sapq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (w_uop),
        .i_en    (!w_hold),
        .o_flags (w_flags),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // words only enter in the wait step and go straight to dispatch
    `SAPQ_ASSERT_NOW(a_accept_in_wait, i_in.valid && i_in.ready, w_step == S_WAIT, "accept outside wait step")
    `SAPQ_ASSERT_NEXT(a_accept_to_disp, i_in.valid && i_in.ready, w_step == S_DISP, "accept not followed by dispatch")
    // a pop never runs on an empty queue
    `SAPQ_ASSERT_NOW(a_pop_not_empty, w_step == S_REM2 && !w_hold, !w_flags.empty, "pop from empty queue")
    // a pop always shows its result word
    `SAPQ_ASSERT_NEXT(a_pop_result, w_uop.op == DP_REM_POP && !w_hold, o_out.valid, "pop without result word")
endmodule

FILE: src/sapq_ram.sv
module sapq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/sapq_seq.sv
module sapq_seq
    import sapq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_flags i_flags,
    output t_uop      o_uop,
    output logic      o_hold,
    output t_step     o_step
);
    t_step r_step;
    t_step n_step;
    t_uop  w_uop;
    logic  w_hold;

    assign w_uop  = ucode(r_step);
    assign w_hold = cond_true(w_uop.hold, i_flags);

    // next step: hold, jump or fall through
    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (cond_true(w_uop.jcond, i_flags)) begin
            n_step = w_uop.target;
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    always_comb begin
        o_uop  = w_uop;
        o_hold = w_hold;
        o_step = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end
endmodule

FILE: src/sapq_dp.sv
module sapq_dp
    import sapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_uop       i_uop,
    input  logic       i_en,
    output t_dp_flags  o_flags,
    sapq_in_if.sink    i_in,
    sapq_out_if.source o_out
);
    localparam int AW = $clog2(DEPTH);

    logic                     r_op;
    logic signed [WORD_W-1:0] r_val;
    logic [AW-1:0]            r_head, r_tail, r_pos;
    logic                     r_empty;
    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [WORD_W-1:0] r_removed;

    logic                     n_op;
    logic signed [WORD_W-1:0] n_val;
    logic [AW-1:0]            n_head, n_tail, n_pos;
    logic                     n_empty;
    logic                     n_out_valid;
    t_status                  n_status;
    logic signed [WORD_W-1:0] n_removed;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata, w_rdata;
    logic              w_walk_more;
    logic              w_accept;

    sapq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (i_uop.op == DP_LATCH);
    assign w_accept   = i_in.valid && i_in.ready;

    // keep walking while above the head and the new word is strictly smaller
    assign w_walk_more = (r_pos > r_head) && (r_val < $signed(w_rdata));

    always_comb begin
        o_flags.in_valid  = i_in.valid;
        o_flags.is_remove = (r_op == OP_REMOVE);
        o_flags.empty     = r_empty;
        o_flags.full      = !r_empty && (r_tail == AW'(DEPTH - 1));
        o_flags.walk_more = w_walk_more;
        o_flags.out_busy  = r_out_valid && !o_out.ready;
    end

    // store port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = w_rdata;
        w_raddr = r_head;
        case (i_uop.op)
            DP_WALK_INIT: w_raddr = r_tail;
            DP_WALK: begin
                w_raddr = (r_pos >= AW'(2)) ? r_pos - AW'(2) : '0;
                w_we    = i_en;
                w_wdata = w_walk_more ? w_rdata : r_val;
            end
            DP_INS_EMPTY: begin
                w_we    = i_en;
                w_waddr = '0;
                w_wdata = r_val;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_val       = r_val;
        n_head      = r_head;
        n_tail      = r_tail;
        n_pos       = r_pos;
        n_empty     = r_empty;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out_valid = r_out_valid && !o_out.ready;
        if (i_en) begin
            case (i_uop.op)
                DP_LATCH: begin
                    if (w_accept) begin
                        n_op  = i_in.operation;
                        n_val = i_in.item_value;
                    end
                end
                DP_WALK_INIT: n_pos = r_tail + AW'(1);
                DP_WALK: begin
                    if (w_walk_more) begin
                        n_pos = r_pos - AW'(1);
                    end else begin
                        n_tail = r_tail + AW'(1);
                    end
                end
                DP_INS_EMPTY: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                end
                DP_RES_OK: begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_removed   = '0;
                end
                DP_RES_OVF: begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OVERFLOW;
                    n_removed   = '0;
                end
                DP_RES_UNF: begin
                    n_out_valid = 1'b1;
                    n_status    = ST_UNDERFLOW;
                    n_removed   = '0;
                end
                DP_REM_POP: begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_removed   = $signed(w_rdata);
                    if (r_head == r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_head = r_head + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed;
endmodule

FILE: tb/tb_sorted_array_priority_queue.sv
module tb_sorted_array_priority_queue
    import sapq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH           = DEPTH_DEFAULT;
    localparam int RANDOM_PER_PHASE = 372;
    // slowest run: ~1550 words plus long gaps and stalls
    localparam int CYCLE_LIMIT      = 600000;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 40;
    localparam int HOLD_OFF_CYCLES  = 300;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct {
        t_status status;
        t_word   value;
    } t_result;

    // directed stimulus: one row may repeat with a stepped value
    typedef struct {
        logic    op;
        t_word   value;
        int      reps;
        int      step;
        bit      typed;
        t_status exp_status;
        t_word   exp_value;
    } t_stim_row;

    localparam int N_ROWS = 17;

    t_stim_row directed_rows [0:N_ROWS-1] = '{
        // removal straight after reset
        '{OP_REMOVE, 32'sd0,          1, 0, 1'b1, ST_UNDERFLOW, 32'sd0},
        // extremes; the first lands in slot 0 of an empty queue
        '{OP_INSERT, 32'sh7fffffff,   1, 0, 1'b1, ST_DONE,      32'sd0},
        '{OP_INSERT, 32'sh80000000,   1, 0, 1'b1, ST_DONE,      32'sd0},
        '{OP_INSERT, -32'sd1,         1, 0, 1'b0, ST_DONE,      32'sd0},
        // removal ignores the value field
        '{OP_REMOVE, 32'sh5a5a5a5a,   1, 0, 1'b1, ST_DONE,      32'sh80000000},
        '{OP_REMOVE, -32'sd1,         1, 0, 1'b1, ST_DONE,      -32'sd1},
        // last entry out, indices rewind
        '{OP_REMOVE, 32'sd0,          1, 0, 1'b1, ST_DONE,      32'sh7fffffff},
        '{OP_INSERT, 32'sd10,         1, 0, 1'b0, ST_DONE,      32'sd0},
        '{OP_INSERT, 32'sd20,         1, 0, 1'b0, ST_DONE,      32'sd0},
        '{OP_INSERT, 32'sd30,         1, 0, 1'b0, ST_DONE,      32'sd0},
        '{OP_REMOVE, 32'sd0,          1, 0, 1'b1, ST_DONE,      32'sd10},
        // smaller than everything with the head off slot 0: walk stops at the head
        '{OP_INSERT, -32'sd5,         1, 0, 1'b0, ST_DONE,      32'sd0},
        // equal value goes behind its twin
        '{OP_INSERT, 32'sd20,         1, 0, 1'b0, ST_DONE,      32'sd0},
        // fill up to the last slot
        '{OP_INSERT, 32'sd0,         11, 1, 1'b0, ST_DONE,      32'sd0},
        '{OP_INSERT, 32'sd0,          1, 0, 1'b1, ST_OVERFLOW,  32'sd0},
        // still full although a head slot is free
        '{OP_REMOVE, 32'sd0,          1, 0, 1'b0, ST_DONE,      32'sd0},
        '{OP_INSERT, 32'sd55,         1, 0, 1'b1, ST_OVERFLOW,  32'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    sapq_in_if  in_chan ();
    sapq_out_if out_chan ();

    sorted_array_priority_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_chan),
        .o_out  (out_chan)
    );

    // predicted queue contents
    t_word   q_slots [QDEPTH];
    int      q_head;
    int      q_tail;
    bit      q_empty;

    t_result expected_words [$];
    int      mismatch_count;
    int      cycle_count;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    int      hold_cycles_left;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic void predict_queue_result(input logic op, input t_word val,
                                                 output t_status st, output t_word rv);
        int pos;
        int k;
        rv = '0;
        st = ST_DONE;
        if (op == OP_INSERT) begin
            if (q_empty) begin
                q_head     = 0;
                q_tail     = 0;
                q_slots[0] = val;
                q_empty    = 1'b0;
            end else if (q_tail >= QDEPTH - 1) begin
                st = ST_OVERFLOW;
            end else begin
                // walk down while strictly smaller, never below the head
                pos = q_tail + 1;
                while (pos > q_head && val < q_slots[pos-1])
                    pos--;
                for (k = q_tail + 1; k > pos; k--)
                    q_slots[k] = q_slots[k-1];
                q_slots[pos] = val;
                q_tail++;
            end
        end else begin
            if (q_empty) begin
                st = ST_UNDERFLOW;
            end else begin
                rv = q_slots[q_head];
                if (q_head >= q_tail) begin
                    q_head  = 0;
                    q_tail  = 0;
                    q_empty = 1'b1;
                end else begin
                    q_head++;
                end
            end
        end
    endfunction

    // offer one word, wait for acceptance, then log what should come back
    task automatic send_word(input logic op, input t_word val, input bit typed,
                             input t_status typed_status, input t_word typed_value);
        t_result want;
        t_status st;
        t_word   rv;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid      <= 1'b1;
        in_chan.operation  <= op;
        in_chan.item_value <= val;
        @(posedge i_clk);
        while (!in_chan.ready)
            @(posedge i_clk);
        predict_queue_result(op, val, st, rv);
        want.status = typed ? typed_status : st;
        want.value  = typed ? typed_value : rv;
        expected_words.push_back(want);
    endtask

    // bursts with a varying insert share so the queue fills, drains and rewinds
    task automatic run_random_words(input int count);
        int    sent;
        int    burst;
        int    insert_pct;
        int    b;
        logic  op;
        t_word val;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(40, 8);
            case ($urandom_range(3))
                0: insert_pct = 25;
                1: insert_pct = 50;
                2: insert_pct = 75;
                default: insert_pct = 90;
            endcase
            for (b = 0; b < burst && sent < count; b++) begin
                op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                case ($urandom_range(5))
                    0, 1, 2: val = $urandom;
                    3:       val = $urandom_range(8) - 4;
                    4:       val = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                    default: val = $urandom_range(1) ? 32'sd0 : -32'sd1;
                endcase
                send_word(op, val, 1'b0, ST_DONE, '0);
                sent++;
            end
        end
    endtask

    // result side: check on the handshake, then pick the next ready
    initial begin
        t_result want;
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_chan.valid && out_chan.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: status %0d value %0d",
                                              out_chan.status, out_chan.removed_value));
                end else begin
                    want = expected_words.pop_front();
                    if (out_chan.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  out_chan.status, want.status));
                    if (out_chan.removed_value !== want.value)
                        report_mismatch($sformatf("removed_value %0d, wanted %0d",
                                                  out_chan.removed_value, want.value));
                end
            end
            if (hold_cycles_left > 0) begin
                hold_cycles_left = hold_cycles_left - 1;
                out_chan.ready <= 1'b0;
            end else begin
                out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int r;
        int k;
        int drain;
        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles_left   = 0;
        q_head             = 0;
        q_tail             = 0;
        q_empty            = 1'b1;
        i_rst_n            <= 1'b0;
        in_chan.valid      <= 1'b0;
        in_chan.operation  <= OP_INSERT;
        in_chan.item_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            for (k = 0; k < directed_rows[r].reps; k++)
                send_word(directed_rows[r].op, directed_rows[r].value + k * directed_rows[r].step,
                          directed_rows[r].typed, directed_rows[r].exp_status,
                          directed_rows[r].exp_value);
        end

        // back to back, with one long hold-off on the result side to fill the block
        hold_cycles_left = HOLD_OFF_CYCLES;
        run_random_words(RANDOM_PER_PHASE);

        sender_idle_pct = 46;
        run_random_words(RANDOM_PER_PHASE);

        sender_idle_pct    = 0;
        receiver_stall_pct = 46;
        run_random_words(RANDOM_PER_PHASE);

        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
        run_random_words(RANDOM_PER_PHASE);

        in_chan.valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (expected_words.size() != 0) begin
            void'(expected_words.pop_front());
            report_mismatch("expected word never arrived");
        end

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/sapq_pkg.sv
src/sapq_if.sv
src/sapq_ram.sv
src/sapq_seq.sv
src/sapq_dp.sv
src/sorted_array_priority_queue.sv
tb/tb_sorted_array_priority_queue.sv
